>>> design/adc_trimmed_mean_averager_assert.svh
// assertion macros for the adc trimmed mean averager
`ifndef ADC_TRIMMED_MEAN_AVERAGER_ASSERT_SVH
`define ADC_TRIMMED_MEAN_AVERAGER_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define ATMA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trimmed mean averager: assertion failed");
// antecedent implies consequent in the next cycle
`define ATMA_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trimmed mean averager: assertion failed");
`else
`define ATMA_ASSERT_IMP(name, clk, rst, ante, cons)
`define ATMA_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

>>> design/atma_pkg.sv
// types and constants shared by the adc trimmed mean averager
`default_nettype none
package atma_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CHAN_W         = 7;
  localparam int TRIM_EACH_SIDE = 3;
  // divisor stays below this bound, sets the extra reciprocal precision
  localparam int DIV_MAX        = 64;

  // operation codes
  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_AVERAGE = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
  } atma_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          result_channel;
    logic signed [SAMPLE_W-1:0] average;
  } atma_rsp_t;

  // control of the min/max/sum collector
  typedef struct packed {
    logic clear;
    logic take;
  } atma_trim_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_TRIM,
    ST_DIV,
    ST_OUT
  } atma_state_t;

endpackage
`default_nettype wire

>>> design/atma_hist_mem.sv
// sample history memory, one write port and one registered read port
`default_nettype none
module atma_hist_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        waddr,
  input  logic signed [atma_pkg::SAMPLE_W-1:0] wdata,
  input  logic                                 re,
  input  logic [AW-1:0]                        raddr,
  output logic signed [atma_pkg::SAMPLE_W-1:0] rdata
);
  import atma_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered output held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/atma_trim_unit.sv
// running sum plus the three smallest and three largest samples of one channel
`default_nettype none
module atma_trim_unit #(
  parameter int SW = 20
) (
  input  logic                                 clk,
  input  atma_pkg::atma_trim_ctl_t             ctl,
  input  logic signed [atma_pkg::SAMPLE_W-1:0] smp,
  output logic signed [SW-1:0]                 trimmed
);
  import atma_pkg::*;

  logic signed [SW-1:0]       sum;
  logic signed [SAMPLE_W-1:0] lo [TRIM_EACH_SIDE];
  logic signed [SAMPLE_W-1:0] hi [TRIM_EACH_SIDE];
  logic signed [SAMPLE_W-1:0] lo_next [TRIM_EACH_SIDE];
  logic signed [SAMPLE_W-1:0] hi_next [TRIM_EACH_SIDE];

  // insert into the ascending smallest list
  always_comb begin
    lo_next = lo;
    if (smp < lo[0]) begin
      lo_next[0] = smp;
      lo_next[1] = lo[0];
      lo_next[2] = lo[1];
    end else if (smp < lo[1]) begin
      lo_next[1] = smp;
      lo_next[2] = lo[1];
    end else if (smp < lo[2]) begin
      lo_next[2] = smp;
    end
  end

  // insert into the descending largest list
  always_comb begin
    hi_next = hi;
    if (smp > hi[0]) begin
      hi_next[0] = smp;
      hi_next[1] = hi[0];
      hi_next[2] = hi[1];
    end else if (smp > hi[1]) begin
      hi_next[1] = smp;
      hi_next[2] = hi[1];
    end else if (smp > hi[2]) begin
      hi_next[2] = smp;
    end
  end

  // collector registers, lists start at the opposite extreme
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum <= '0;
      for (int i = 0; i < TRIM_EACH_SIDE; i++) begin
        lo[i] <= 16'sh7FFF;
        hi[i] <= 16'sh8000;
      end
    end else if (ctl.take) begin
      sum <= sum + SW'(smp);
      lo  <= lo_next;
      hi  <= hi_next;
    end
  end

  // sum with the outer samples removed
  assign trimmed = sum - SW'(lo[0]) - SW'(lo[1]) - SW'(lo[2])
                       - SW'(hi[0]) - SW'(hi[1]) - SW'(hi[2]);

endmodule
`default_nettype wire

>>> design/atma_div_unit.sv
// pipelined signed divide by a constant, reciprocal multiply with one correction
`default_nettype none
module atma_div_unit #(
  parameter int SW      = 20,
  parameter int DIVISOR = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [SW-1:0]                 dividend,
  output logic                                 done,
  output logic signed [atma_pkg::SAMPLE_W-1:0] quotient
);
  import atma_pkg::*;

  localparam int         SH    = SW + $clog2(DIV_MAX);
  localparam int         PRODW = SW + SH + 1;
  localparam logic [SH:0] RECIP = (SH+1)'((longint'(1) << SH) / DIVISOR);

  logic                 v0, v1, v2;
  logic signed [SW-1:0] dvd;
  logic [SW-1:0]        mag1, mag2;
  logic                 neg1, neg2;
  logic [PRODW-1:0]     prod;
  logic [SW-1:0]        q0, qd, rem, qc;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start;
      v1   <= v0;
      v2   <= v1;
      done <= v2;
    end
  end

  // estimate is exact or one low, fixed by one remainder compare
  always_comb begin
    q0  = prod[SH +: SW];
    qd  = q0 * SW'(DIVISOR);
    rem = mag2 - qd;
    qc  = (rem >= SW'(DIVISOR)) ? q0 + 1'b1 : q0;
  end

  // datapath stages: capture, magnitude, multiply, correct
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (v0) begin
      neg1 <= dvd[SW-1];
      mag1 <= dvd[SW-1] ? SW'(-dvd) : SW'(dvd);
    end
    if (v1) begin
      neg2 <= neg1;
      mag2 <= mag1;
      prod <= PRODW'(mag1) * PRODW'(RECIP);
    end
    if (v2) begin
      quotient <= neg2 ? -qc[SAMPLE_W-1:0] : qc[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> design/adc_trimmed_mean_averager.sv
// top level: per-channel sample history with trimmed mean readout
//
// Request words arrive on req (req_valid / req_stall), result words leave
// on rsp (rsp_valid / rsp_stall). A word is taken when valid is high and
// stall is low. A store word writes its sample at the shared slot pointer
// and gives no result; out of range channels are not written. frame_end on
// any word advances the slot pointer after that word's action.
// An average word reads the channel's SAMPLES_PER_CHANNEL samples from the
// history memory, one per cycle through its single read port, collects the
// sum and the three smallest and largest, then divides in a four stage
// reciprocal pipeline; for a channel out of range it reads nothing and gives
// zero. The request passes ST_READ, ST_DRAIN, ST_TRIM, ST_DIV and ST_OUT,
// and no new word is taken before the result is in the output register.
// After reset the memory is cleared one entry a cycle, through all
// CHANNELS * SAMPLES_PER_CHANNEL entries (2048 at the defaults); req_stall
// stays high meanwhile. A stalled result waits in the output register,
// while store words keep being taken; a next average is taken, but its
// result waits in ST_OUT until the output register is free.
`default_nettype none
`include "adc_trimmed_mean_averager_assert.svh"
module adc_trimmed_mean_averager #(
  parameter int SAMPLES_PER_CHANNEL = 16,
  parameter int CHANNELS            = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  atma_pkg::atma_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output atma_pkg::atma_rsp_t rsp
);
  import atma_pkg::*;

  localparam int DEPTH   = CHANNELS * SAMPLES_PER_CHANNEL;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = $clog2(SAMPLES_PER_CHANNEL);
  localparam int SW      = SAMPLE_W + $clog2(SAMPLES_PER_CHANNEL);
  localparam int DIVISOR = SAMPLES_PER_CHANNEL - 2 * TRIM_EACH_SIDE;

  atma_state_t                state, state_next;
  logic [PW-1:0]              slot;
  logic [PW-1:0]              rd_cnt;
  logic                       rd_last;
  logic [AW-1:0]              clr_addr;
  logic [AW-1:0]              base;
  logic [CHAN_W-1:0]          ch_hold;
  logic                       ch_ok;
  logic                       rd_pend;
  logic                       req_take, req_in_range, rsp_free;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic signed [SAMPLE_W-1:0] mem_wdata, mem_rdata;
  atma_trim_ctl_t             trim_ctl;
  logic signed [SW-1:0]       trimmed;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_q;

  // handshake and address decode
  assign req_stall    = (state != ST_IDLE);
  assign req_take     = req_valid && !req_stall;
  assign req_in_range = int'(req.channel) < CHANNELS;
  assign rsp_free     = !rsp_valid || !rsp_stall;
  assign rd_last      = (rd_cnt == PW'(SAMPLES_PER_CHANNEL - 1));

  // memory port selection: clearing pass or store word
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = req_take && (req.op == OP_STORE) && req_in_range;
      mem_waddr = AW'(int'(req.channel) * SAMPLES_PER_CHANNEL + int'(slot));
      mem_wdata = req.sample;
    end
  end

  assign mem_re    = (state == ST_READ) && ch_ok;
  assign mem_raddr = base + AW'(rd_cnt);

  assign trim_ctl.clear = req_take && (req.op == OP_AVERAGE);
  assign trim_ctl.take  = rd_pend;

  atma_hist_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  atma_trim_unit #(
    .SW (SW)
  ) u_trim (
    .clk     (clk),
    .ctl     (trim_ctl),
    .smp     (mem_rdata),
    .trimmed (trimmed)
  );

  atma_div_unit #(
    .SW      (SW),
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_TRIM),
    .dividend (trimmed),
    .done     (div_done),
    .quotient (div_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_take && (req.op == OP_AVERAGE)) state_next = ST_READ;
      end
      ST_READ: begin
        if (rd_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_TRIM;
      ST_TRIM:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // counters, slot pointer and read-pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      rd_cnt   <= '0;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= mem_re;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_READ) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (req_take && req.frame_end) begin
        slot <= (slot == PW'(SAMPLES_PER_CHANNEL - 1)) ? '0 : slot + 1'b1;
      end
      if (req_take && (req.op == OP_AVERAGE)) begin
        rd_cnt <= '0;
      end
    end
  end

  // channel of the pending average
  always_ff @(posedge clk) begin
    if (req_take && (req.op == OP_AVERAGE)) begin
      base    <= AW'(int'(req.channel) * SAMPLES_PER_CHANNEL);
      ch_hold <= req.channel;
      ch_ok   <= req_in_range;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_OUT) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && rsp_free) begin
      rsp.result_channel <= ch_hold;
      rsp.average        <= ch_ok ? div_q : '0;
    end
  end

  // checks on sequencing
  `ATMA_ASSERT_NXT(a_read_to_drain, clk, rst, state == ST_READ && rd_last, state == ST_DRAIN)
  `ATMA_ASSERT_IMP(a_done_in_div, clk, rst, div_done, state == ST_DIV)
  `ATMA_ASSERT_IMP(a_store_when_idle, clk, rst, mem_we && state != ST_CLEAR, state == ST_IDLE && !mem_re)
  `ATMA_ASSERT_NXT(a_result_loaded, clk, rst, state == ST_OUT && rsp_free, rsp_valid && state == ST_IDLE)

endmodule
`default_nettype wire
